### design/csvrp_pkg.sv
`timescale 1ns / 1ps

package csvrp_pkg;

   localparam int ByteWidth = 8;

   localparam logic [ByteWidth-1:0] CharBackslash = 8'h5C;
   localparam logic [ByteWidth-1:0] CharCr        = 8'h0D;
   localparam logic [ByteWidth-1:0] CharLf        = 8'h0A;
   localparam logic [ByteWidth-1:0] CharSpace     = 8'h20;
   localparam logic [ByteWidth-1:0] CharTab       = 8'h09;
   localparam logic [ByteWidth-1:0] CharVt        = 8'h0B;
   localparam logic [ByteWidth-1:0] CharFf        = 8'h0C;

   localparam logic [ByteWidth-1:0] DelimiterReset = 8'd44;
   localparam logic [ByteWidth-1:0] EnclosureReset = 8'd34;

   // configuration register indexes
   typedef enum logic [0:0] {
      REG_DELIMITER = 1'b0,
      REG_ENCLOSURE = 1'b1
   } reg_index_type;

   typedef enum logic [2:0] {
      MODE_LINE_START  = 3'd0,
      MODE_FIELD_START = 3'd1,
      MODE_UNQUOTED    = 3'd2,
      MODE_QUOTED      = 3'd3,
      MODE_ESCAPED     = 3'd4,
      MODE_QUOTE_SEEN  = 3'd5
   } mode_type;

   typedef struct packed {
      mode_type parse_mode;
      logic     cr_pending;
      logic     field_started;
   } parse_state_type;

   typedef struct packed {
      logic [ByteWidth-1:0] in_byte;
      logic                 end_of_stream;
   } req_type;

   typedef struct packed {
      logic [ByteWidth-1:0] out_byte;
      logic                 byte_valid;
      logic                 field_end;
      logic                 record_end;
      logic                 null_field;
      logic                 last;
   } rsp_type;

endpackage

### design/csvrp_step.sv
`timescale 1ns / 1ps

module csvrp_step (
   input  csvrp_pkg::parse_state_type cur_state,
   input  csvrp_pkg::req_type         req,
   input  logic [7:0]                 delimiter,
   input  logic [7:0]                 enclosure,
   output csvrp_pkg::parse_state_type nxt_state,
   output logic                       hit,
   output csvrp_pkg::rsp_type         rsp
);
   import csvrp_pkg::*;

   logic [ByteWidth-1:0] b;
   logic                 eol;
   logic                 blank;
   logic                 do_close;
   logic                 close_eol;

   assign b     = req.in_byte;
   assign eol   = (b == CharCr) || (b == CharLf);
   assign blank = (b == CharSpace) || (b == CharTab) || (b == CharVt) || (b == CharFf);

   always_comb begin
      nxt_state = cur_state;
      hit       = 1'b0;
      rsp       = '0;
      rsp.last  = 1'b1;
      do_close  = 1'b0;
      close_eol = 1'b0;

      if (req.end_of_stream) begin
         do_close             = 1'b1;
         nxt_state.cr_pending = 1'b0;
      end else if (cur_state.cr_pending && (b == CharLf)) begin
         // lf of a crlf pair, already reported
         nxt_state.cr_pending = 1'b0;
      end else begin
         nxt_state.cr_pending = 1'b0;
         unique case (cur_state.parse_mode)
            MODE_QUOTED: begin
               hit          = 1'b1;
               rsp.out_byte = b;
               rsp.byte_valid = 1'b1;
               if (eol) begin
                  nxt_state.parse_mode = MODE_QUOTED;
               end else if (b == CharBackslash) begin
                  nxt_state.parse_mode = MODE_ESCAPED;
               end else if (b == enclosure) begin
                  nxt_state.parse_mode = MODE_QUOTE_SEEN;
                  hit            = 1'b0;
                  rsp.out_byte   = '0;
                  rsp.byte_valid = 1'b0;
               end
            end
            MODE_ESCAPED: begin
               nxt_state.parse_mode = MODE_QUOTED;
               hit            = 1'b1;
               rsp.out_byte   = b;
               rsp.byte_valid = 1'b1;
            end
            MODE_QUOTE_SEEN: begin
               if (eol) begin
                  do_close  = 1'b1;
                  close_eol = 1'b1;
               end else if (b == enclosure) begin
                  nxt_state.parse_mode = MODE_QUOTED;
                  hit            = 1'b1;
                  rsp.out_byte   = b;
                  rsp.byte_valid = 1'b1;
               end else if (b == delimiter) begin
                  nxt_state.parse_mode    = MODE_FIELD_START;
                  nxt_state.field_started = 1'b0;
                  hit           = 1'b1;
                  rsp.field_end = 1'b1;
               end else begin
                  nxt_state.parse_mode = MODE_UNQUOTED;
                  hit            = 1'b1;
                  rsp.out_byte   = b;
                  rsp.byte_valid = 1'b1;
               end
            end
            MODE_UNQUOTED: begin
               if (eol) begin
                  do_close  = 1'b1;
                  close_eol = 1'b1;
               end else if (b == delimiter) begin
                  nxt_state.parse_mode    = MODE_FIELD_START;
                  nxt_state.field_started = 1'b0;
                  hit           = 1'b1;
                  rsp.field_end = 1'b1;
               end else begin
                  hit            = 1'b1;
                  rsp.out_byte   = b;
                  rsp.byte_valid = 1'b1;
               end
            end
            default: begin
               // line start, field start and unused codes
               if (eol) begin
                  do_close  = 1'b1;
                  close_eol = 1'b1;
               end else if (blank && (b != delimiter)) begin
                  nxt_state.field_started = 1'b1;
               end else begin
                  nxt_state.field_started = 1'b0;
                  if (b == enclosure) begin
                     nxt_state.parse_mode = MODE_QUOTED;
                  end else if (b == delimiter) begin
                     nxt_state.parse_mode = MODE_FIELD_START;
                     hit           = 1'b1;
                     rsp.field_end = 1'b1;
                  end else begin
                     nxt_state.parse_mode = MODE_UNQUOTED;
                     hit            = 1'b1;
                     rsp.out_byte   = b;
                     rsp.byte_valid = 1'b1;
                  end
               end
            end
         endcase
         if (close_eol) begin
            nxt_state.cr_pending = (b == CharCr);
         end
      end

      if (do_close) begin
         rsp      = '0;
         rsp.last = 1'b1;
         unique case (cur_state.parse_mode)
            MODE_FIELD_START: begin
               hit            = 1'b1;
               rsp.field_end  = cur_state.field_started;
               rsp.record_end = 1'b1;
            end
            MODE_UNQUOTED, MODE_QUOTED, MODE_ESCAPED, MODE_QUOTE_SEEN: begin
               hit            = 1'b1;
               rsp.field_end  = 1'b1;
               rsp.record_end = 1'b1;
            end
            default: begin
               // blank line gives one null field
               hit            = close_eol || cur_state.field_started;
               rsp.field_end  = 1'b1;
               rsp.record_end = 1'b1;
               rsp.null_field = 1'b1;
            end
         endcase
         nxt_state.parse_mode    = MODE_LINE_START;
         nxt_state.field_started = 1'b0;
      end
   end

endmodule

### design/csv_record_parser.sv
`timescale 1ns / 1ps

// csv record parser: splits a byte stream into fields and records
// - req channel: one word per byte (in_byte), or an end_of_stream word that
//   flushes a held line and closes any open record
// - rsp channel: at most one word per request word: a field byte, or a mark
//   with field_end / record_end / null_field; last is always set
// - csr port: write-only, index 0 delimiter, index 1 enclosure; write only
//   while the block is idle
// - one byte per cycle sustained while rsp is not stalled: an input register
//   feeds a single combinational parse step that updates the parser state and
//   loads the result register in the same cycle
// - an accepted byte waits in the input register, and its result word is then
//   loaded into the result register, where rsp_valid rises
// - a byte that gives no result (skipped blank, quote, lf after cr) just
//   advances the parser state
// - when rsp is stalled the result register holds, the input register holds
//   its byte and req_stall rises once that register is full
// - reset (synchronous) empties both registers, returns the parser to line
//   start and restores delimiter ',' and enclosure '"'
module csv_record_parser (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  csvrp_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output csvrp_pkg::rsp_type rsp_data,
   input  logic               csr_write,
   input  logic [0:0]         csr_index,
   input  logic [7:0]         csr_wdata
);
   import csvrp_pkg::*;

   // configuration registers
   logic [ByteWidth-1:0] delimiter_ff;
   logic [ByteWidth-1:0] enclosure_ff;

   // input register
   logic    in_valid_ff;
   req_type in_data_ff;

   // parser state and result register
   parse_state_type state_ff;
   parse_state_type state_in;
   logic            rsp_valid_ff;
   rsp_type         rsp_data_ff;
   rsp_type         rsp_in;
   logic            hit;

   // the step stage moves when the result register is free or being taken
   logic advance;

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = in_valid_ff && !advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         delimiter_ff <= DelimiterReset;
         enclosure_ff <= EnclosureReset;
      end else if (csr_write) begin
         unique case (reg_index_type'(csr_index))
            REG_DELIMITER: delimiter_ff <= csr_wdata;
            REG_ENCLOSURE: enclosure_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // input register loads whenever it is not holding a stalled word
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall && req_valid) begin
         in_data_ff <= req_data;
      end
   end

   csvrp_step u_step (
      .cur_state (state_ff),
      .req       (in_data_ff),
      .delimiter (delimiter_ff),
      .enclosure (enclosure_ff),
      .nxt_state (state_in),
      .hit       (hit),
      .rsp       (rsp_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= '{parse_mode: MODE_LINE_START, cr_pending: 1'b0,
                           field_started: 1'b0};
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= in_valid_ff && hit;
         if (in_valid_ff) begin
            state_ff <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance && in_valid_ff && hit) begin
         rsp_data_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

### design/csvrp_checker.sv
`timescale 1ns / 1ps

module csvrp_checker (
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input csvrp_pkg::rsp_type rsp_data
);
   import csvrp_pkg::*;

   // result register comes out of reset empty
   a_empty_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("rsp_valid high right after reset");

   a_byte_no_marks: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.byte_valid |->
         !rsp_data.field_end && !rsp_data.record_end && !rsp_data.null_field)
      else $error("field byte carries an end mark");

   a_null_closes: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.null_field |->
         rsp_data.field_end && rsp_data.record_end)
      else $error("null field without field and record end");

   a_mark_zero_byte: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.byte_valid |->
         (rsp_data.out_byte == '0) && (rsp_data.record_end || rsp_data.field_end))
      else $error("mark word without an end flag or with a nonzero byte");

   a_last_set: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.last)
      else $error("result word without last");

endmodule

bind csv_record_parser csvrp_checker u_csvrp_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);

### tb/csv_field_checker.sv
`timescale 1ns / 1ps

module csv_field_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  csvrp_pkg::req_type req_data,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  csvrp_pkg::rsp_type rsp_data,
   input  logic               csr_write,
   input  logic [0:0]         csr_index,
   input  logic [7:0]         csr_wdata,
   output int                 fail_count,
   output int                 words_owed,
   output int                 words_checked
);
   import csvrp_pkg::*;

   logic [7:0] delim;
   logic [7:0] encl;
   mode_type   mode;
   logic       cr_held;
   logic       blank_seen;
   rsp_type    field_words [$];
   rsp_type    predicted;
   rsp_type    oldest;

   // close the record in the current mode; eol is a real line end
   function automatic logic close_line(input logic eol, output rsp_type r);
      logic hit;
      r      = '0;
      r.last = 1'b1;
      hit    = 1'b1;
      case (mode)
         MODE_FIELD_START: begin
            r.field_end  = blank_seen;
            r.record_end = 1'b1;
         end
         MODE_UNQUOTED, MODE_QUOTED, MODE_ESCAPED, MODE_QUOTE_SEEN: begin
            r.field_end  = 1'b1;
            r.record_end = 1'b1;
         end
         default: begin
            if (eol || blank_seen) begin
               r.field_end  = 1'b1;
               r.record_end = 1'b1;
               r.null_field = 1'b1;
            end else begin
               hit = 1'b0;
            end
         end
      endcase
      mode       = MODE_LINE_START;
      blank_seen = 1'b0;
      return hit;
   endfunction

   // one request word in, at most one result word out
   function automatic logic split_byte(input req_type w, output rsp_type r);
      logic [7:0] b;
      logic       eol;
      logic       hit;
      logic       sep;
      logic       close_now;
      r      = '0;
      r.last = 1'b1;
      if (w.end_of_stream) begin
         cr_held = 1'b0;
         return close_line(1'b0, r);
      end
      b = w.in_byte;
      if (cr_held) begin
         cr_held = 1'b0;
         if (b == CharLf) return 1'b0;
      end
      eol       = (b == CharCr) || (b == CharLf);
      hit       = 1'b0;
      sep       = 1'b0;
      close_now = 1'b0;
      case (mode)
         MODE_QUOTED: begin
            if (eol) hit = 1'b1;
            else if (b == CharBackslash) begin
               mode = MODE_ESCAPED;
               hit  = 1'b1;
            end else if (b == encl) mode = MODE_QUOTE_SEEN;
            else hit = 1'b1;
         end
         MODE_ESCAPED: begin
            mode = MODE_QUOTED;
            hit  = 1'b1;
         end
         MODE_QUOTE_SEEN: begin
            if (eol) close_now = 1'b1;
            else if (b == encl) begin
               mode = MODE_QUOTED;
               hit  = 1'b1;
            end else if (b == delim) sep = 1'b1;
            else begin
               mode = MODE_UNQUOTED;
               hit  = 1'b1;
            end
         end
         MODE_UNQUOTED: begin
            if (eol) close_now = 1'b1;
            else if (b == delim) sep = 1'b1;
            else hit = 1'b1;
         end
         default: begin
            if (eol) close_now = 1'b1;
            else if ((b == CharSpace || b == CharTab || b == CharVt || b == CharFf)
                     && b != delim) blank_seen = 1'b1;
            else begin
               blank_seen = 1'b0;
               if (b == encl) mode = MODE_QUOTED;
               else if (b == delim) sep = 1'b1;
               else begin
                  mode = MODE_UNQUOTED;
                  hit  = 1'b1;
               end
            end
         end
      endcase
      if (hit) begin
         r.out_byte   = b;
         r.byte_valid = 1'b1;
      end
      if (sep) begin
         mode        = MODE_FIELD_START;
         blank_seen  = 1'b0;
         r.field_end = 1'b1;
         hit         = 1'b1;
      end
      if (close_now) begin
         hit     = close_line(1'b1, r);
         cr_held = (b == CharCr);
      end
      return hit;
   endfunction

   task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         delim      = DelimiterReset;
         encl       = EnclosureReset;
         mode       = MODE_LINE_START;
         cr_held    = 1'b0;
         blank_seen = 1'b0;
         field_words.delete();
      end else begin
         if (csr_write) begin
            if (csr_index == REG_DELIMITER) delim = csr_wdata;
            else encl = csr_wdata;
         end
         if (rsp_valid && !rsp_stall) begin
            if (field_words.size() == 0) begin
               $error("rsp word %0h with nothing predicted", rsp_data);
               fail_count++;
            end else begin
               oldest = field_words.pop_front();
               check_field("out_byte", oldest.out_byte, rsp_data.out_byte);
               check_field("byte_valid", oldest.byte_valid, rsp_data.byte_valid);
               check_field("field_end", oldest.field_end, rsp_data.field_end);
               check_field("record_end", oldest.record_end, rsp_data.record_end);
               check_field("null_field", oldest.null_field, rsp_data.null_field);
               check_field("last", oldest.last, rsp_data.last);
               words_checked++;
            end
         end
         if (req_valid && !req_stall) begin
            if (split_byte(req_data, predicted)) field_words.push_back(predicted);
         end
      end
      words_owed = field_words.size();
   end

endmodule

### tb/tb_csv_record_parser.sv
`timescale 1ns / 1ps

module tb_csv_record_parser;
   import csvrp_pkg::*;

   // delimiter/enclosure settings walked through after the directed part
   localparam int Settings    = 7;
   localparam int PhaseWords  = 25;
   localparam int IdlePercent = 9;
   localparam int HoldCycles  = 80;
   // extra wait once every predicted word is back, as margin
   localparam int DrainCycles = 6;

   logic       clock = 1'b0;
   logic       reset;
   logic       req_valid;
   logic       req_stall;
   req_type    req_data;
   logic       rsp_valid;
   logic       rsp_stall;
   rsp_type    rsp_data;
   logic       csr_write;
   logic [0:0] csr_index;
   logic [7:0] csr_wdata;

   int         fail_count;
   int         words_owed;
   int         words_checked;

   // stimulus bookkeeping
   int         sent;
   int         goal;
   int         phase;
   int         hold_req;
   int         hold_served;
   logic       idle_on;
   logic [7:0] delim_now;
   logic [7:0] encl_now;

   csv_record_parser i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   csv_field_checker i_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_data      (rsp_data),
      .csr_write     (csr_write),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .fail_count    (fail_count),
      .words_owed    (words_owed),
      .words_checked (words_checked)
   );

   // 2 ns clock
   always #1 clock = ~clock;

   // one request word: random idle gaps before it, then hold until accepted
   task automatic send_word(input req_type w);
      @(negedge clock);
      while (idle_on && $urandom_range(99) < IdlePercent) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sent++;
   endtask

   task automatic send_byte(input logic [7:0] b);
      req_type w;
      w.in_byte       = b;
      w.end_of_stream = 1'b0;
      send_word(w);
   endtask

   // end of stream carries a random don't-care byte
   task automatic send_eos();
      req_type w;
      w.in_byte       = 8'($urandom_range(255));
      w.end_of_stream = 1'b1;
      send_word(w);
   endtask

   // sender goes quiet until every predicted word is back and the pipe is empty
   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      wait (words_owed == 0);
      repeat (DrainCycles) @(posedge clock);
   endtask

   task automatic write_reg(input reg_index_type idx, input logic [7:0] value);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_write <= 1'b0;
   endtask

   task automatic load_setting(input int p);
      logic [7:0] d;
      logic [7:0] e;
      case (p)
         0: begin
            d = DelimiterReset;
            e = EnclosureReset;
         end
         1: begin
            d = 8'h00;
            e = 8'hFF;
         end
         2: begin
            d = 8'hFF;
            e = 8'h00;
         end
         3: begin
            // tab as delimiter must not be skipped as a blank
            d = CharTab;
            e = 8'h27;
         end
         4: begin
            // same byte for both: enclosure wins at a field start
            d = 8'h3B;
            e = 8'h3B;
         end
         5: begin
            // backslash as enclosure: escape test comes first inside quotes
            d = CharSpace;
            e = CharBackslash;
         end
         default: begin
            // line end bytes in the registers still act as line ends
            d = CharLf;
            e = CharCr;
         end
      endcase
      write_reg(REG_DELIMITER, d);
      write_reg(REG_ENCLOSURE, e);
      delim_now = d;
      encl_now  = e;
   endtask

   // byte mix biased toward the bytes the parser reacts to
   function automatic logic [7:0] pick_byte();
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 18) return delim_now;
      else if (roll < 26) return encl_now;
      else if (roll < 33) return CharCr;
      else if (roll < 40) return CharLf;
      else if (roll < 48) begin
         case ($urandom_range(3))
            0:       return CharSpace;
            1:       return CharTab;
            2:       return CharVt;
            default: return CharFf;
         endcase
      end else if (roll < 52) return CharBackslash;
      else if (roll < 65) return 8'($urandom_range(255));
      else return 8'h61 + 8'($urandom_range(25));
   endfunction

   // a loose byte, an end of stream, or a whole quoted field with random content
   task automatic send_token();
      int unsigned roll;
      int          n;
      roll = $urandom_range(99);
      if (roll < 4) begin
         send_eos();
      end else if (roll < 32) begin
         send_byte(encl_now);
         n = $urandom_range(5, 1);
         repeat (n) begin
            case ($urandom_range(5))
               0: begin
                  // doubled enclosure
                  send_byte(encl_now);
                  send_byte(encl_now);
               end
               1: begin
                  // escaped byte
                  send_byte(CharBackslash);
                  send_byte(pick_byte());
               end
               2:       send_byte($urandom_range(1) ? CharCr : CharLf);
               default: send_byte(pick_byte());
            endcase
         end
         send_byte(encl_now);
         case ($urandom_range(3))
            0:       send_byte(delim_now);
            1:       send_byte(CharCr);
            2:       send_byte(CharLf);
            default: send_byte(pick_byte());
         endcase
      end else begin
         send_byte(pick_byte());
      end
   endtask

   // directed part under the reset settings
   task automatic run_directed();
      // skipped blank, quoted field with a doubled quote, an escaped quote and a
      // cr as content, then a byte after the closing quote and a delimiter
      send_byte(CharSpace); send_byte(encl_now); send_byte(8'h61); send_byte(encl_now);
      send_byte(encl_now); send_byte(CharBackslash); send_byte(encl_now);
      send_byte(CharCr); send_byte(encl_now); send_byte(8'h7A); send_byte(delim_now);
      // blank after the delimiter then lf: an empty field ends the record
      send_byte(CharSpace); send_byte(CharLf);
      // extreme byte, delimiter at line end, lone cr
      send_byte(8'hFF); send_byte(delim_now); send_byte(CharCr);
      // byte after a held cr that is not lf, then crlf
      send_byte(8'h00); send_byte(CharCr); send_byte(CharLf);
      // blank line gives a null field
      send_byte(CharLf);
      // end of stream after whitespace only, then on an empty line
      send_byte(CharTab); send_eos();
      send_eos();
      // end of stream closes an open quoted field
      send_byte(encl_now); send_byte(8'h71); send_eos();
   endtask

   // receiver: random stalls, a quiet stretch, and one long hold-off on request
   initial begin
      rsp_stall   = 1'b0;
      hold_served = 0;
      forever begin
         @(negedge clock);
         if (hold_req != hold_served) begin
            hold_served = hold_req;
            rsp_stall <= 1'b1;
            repeat (HoldCycles) @(negedge clock);
         end else begin
            rsp_stall <= idle_on && ($urandom_range(99) < IdlePercent);
         end
      end
   end

   // stimulus and verdict
   initial begin
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      csr_write = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      idle_on   = 1'b1;
      sent      = 0;
      hold_req  = 0;
      delim_now = DelimiterReset;
      encl_now  = EnclosureReset;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      run_directed();

      for (phase = 0; phase < Settings; phase++) begin
         settle();
         load_setting(phase);
         // one phase with no idling on either side
         idle_on = (phase != 3);
         // long receiver hold-off while the sender keeps pushing
         if (phase == 1) hold_req++;
         goal = sent + PhaseWords;
         while (sent < goal) send_token();
      end

      settle();
      $display("covered %0d request words over %0d delimiter/enclosure settings,",
               sent, Settings);
      $display("%0d result words checked, with stalls, a long hold-off and gaps",
               words_checked);
      if (fail_count == 0) $display("end of test: clean");
      else $display("end of test: mismatches");
      $finish;
   end

   // watchdog
   initial begin
      #200000;
      $error("timeout with %0d result words still owed", words_owed);
      $display("end of test: mismatches");
      $finish;
   end

endmodule
